// ----- hdl/sif_pkg.sv -----
// shared types, constants and microprogram rom of the instruction packet framer
package sif_pkg;

   localparam int STEP_W = 3;
   localparam int PARAM_FIELDS = 4;
   localparam int IDX_W = 2;
   localparam int COUNT_W = 3;
   localparam logic [7:0] HEADER_BYTE = 8'hFF;
   localparam logic [7:0] LENGTH_EXTRA = 8'd2;

   localparam logic [STEP_W-1:0] STEP_WAIT  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_HDR0  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_HDR1  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_ID    = 3'd3;
   localparam logic [STEP_W-1:0] STEP_LEN   = 3'd4;
   localparam logic [STEP_W-1:0] STEP_INSTR = 3'd5;
   localparam logic [STEP_W-1:0] STEP_PARAM = 3'd6;
   localparam logic [STEP_W-1:0] STEP_CSUM  = 3'd7;

   typedef enum logic [2:0] {
      SRC_HDR,
      SRC_ID,
      SRC_LEN,
      SRC_INSTR,
      SRC_PARAM,
      SRC_CSUM
   } src_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_ALWAYS,
      JMP_NO_PARAMS,
      JMP_MORE_PARAMS
   } jmp_type;

   typedef struct packed {
      logic              wait_in;
      logic              emit;
      logic              last;
      logic              next_param;
      src_type           src;
      acc_type           acc;
      jmp_type           jmp;
      logic [STEP_W-1:0] target;
   } uword_type;

   typedef struct packed {
      uword_type word;
      logic      fire;
   } ctrl_type;

   typedef struct packed {
      logic out_free;
      logic no_params;
      logic more_params;
   } status_type;

   function automatic uword_type sif_rom(input logic [STEP_W-1:0] step);
      uword_type w;
      w = '{wait_in: 1'b0, emit: 1'b1, last: 1'b0, next_param: 1'b0, src: SRC_HDR,
            acc: ACC_HOLD, jmp: JMP_NONE, target: STEP_WAIT};
      case (step)
         STEP_WAIT: begin
            w.wait_in = 1'b1;
            w.emit = 1'b0;
         end
         STEP_HDR0, STEP_HDR1: begin
            w.src = SRC_HDR;
         end
         STEP_ID: begin
            w.src = SRC_ID;
            w.acc = ACC_LOAD;
         end
         STEP_LEN: begin
            w.src = SRC_LEN;
            w.acc = ACC_ADD;
         end
         STEP_INSTR: begin
            w.src = SRC_INSTR;
            w.acc = ACC_ADD;
            w.jmp = JMP_NO_PARAMS;
            w.target = STEP_CSUM;
         end
         STEP_PARAM: begin
            w.src = SRC_PARAM;
            w.acc = ACC_ADD;
            w.next_param = 1'b1;
            w.jmp = JMP_MORE_PARAMS;
            w.target = STEP_PARAM;
         end
         STEP_CSUM: begin
            w.src = SRC_CSUM;
            w.last = 1'b1;
            w.jmp = JMP_ALWAYS;
            w.target = STEP_WAIT;
         end
         default: begin
            w.emit = 1'b0;
            w.jmp = JMP_ALWAYS;
            w.target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- hdl/sif_seq.sv -----
// microprogram sequencer: step counter, control rom and conditional jumps
module sif_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sif_pkg::status_type status,
   output sif_pkg::ctrl_type   ctrl
);
   import sif_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   uword_type         word;
   logic              fire;

   always_comb begin
      word = sif_rom(step_ff);
      // the wait step fires on an accepted item, every other step on a free output slot
      fire = word.wait_in ? (req_tvalid && !reset) : status.out_free;
      step_in = step_ff;
      if (fire) begin
         case (word.jmp)
            JMP_NONE:        step_in = step_ff + 1'b1;
            JMP_ALWAYS:      step_in = word.target;
            JMP_NO_PARAMS:   step_in = status.no_params ? word.target : step_ff + 1'b1;
            JMP_MORE_PARAMS: step_in = status.more_params ? word.target : step_ff + 1'b1;
            default:         step_in = STEP_WAIT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   // no item is taken while reset is held
   assign req_tready = word.wait_in && !reset;
   assign ctrl.word = word;
   assign ctrl.fire = fire;

endmodule

// ----- hdl/sif_dp.sv -----
// datapath: command registers, byte select, checksum accumulator, output register
module sif_dp #(
   parameter int PARAM_LIMIT = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  sif_pkg::ctrl_type   ctrl,
   input  logic [55:0]         req_tdata,
   output sif_pkg::status_type status,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);
   import sif_pkg::*;

   logic [7:0]         id_ff;
   logic [7:0]         instr_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [7:0]         param_ff [PARAM_FIELDS];
   logic [IDX_W-1:0]   idx_ff;
   logic [7:0]         acc_ff;
   logic               valid_ff;
   logic [7:0]         data_ff;
   logic               last_ff;

   logic [COUNT_W-1:0] count_in;
   logic [7:0]         byte_sel;
   logic [COUNT_W-1:0] idx_next;

   always_comb begin
      count_in = req_tdata[18:16];
      if (count_in > COUNT_W'(PARAM_LIMIT)) begin
         count_in = COUNT_W'(PARAM_LIMIT);
      end
      case (ctrl.word.src)
         SRC_HDR:   byte_sel = HEADER_BYTE;
         SRC_ID:    byte_sel = id_ff;
         SRC_LEN:   byte_sel = {5'd0, count_ff} + LENGTH_EXTRA;
         SRC_INSTR: byte_sel = instr_ff;
         SRC_PARAM: byte_sel = param_ff[idx_ff];
         SRC_CSUM:  byte_sel = ~acc_ff;
         default:   byte_sel = HEADER_BYTE;
      endcase
      idx_next = {1'b0, idx_ff} + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (ctrl.fire && ctrl.word.wait_in) begin
         id_ff <= req_tdata[7:0];
         instr_ff <= req_tdata[15:8];
         count_ff <= count_in;
         param_ff[0] <= req_tdata[26:19];
         param_ff[1] <= req_tdata[34:27];
         param_ff[2] <= req_tdata[42:35];
         param_ff[3] <= req_tdata[50:43];
         idx_ff <= '0;
      end else if (ctrl.fire && ctrl.word.next_param) begin
         idx_ff <= idx_next[IDX_W-1:0];
      end
      if (ctrl.fire) begin
         case (ctrl.word.acc)
            ACC_LOAD: acc_ff <= byte_sel;
            ACC_ADD:  acc_ff <= acc_ff + byte_sel;
            default:  acc_ff <= acc_ff;
         endcase
      end
      if (ctrl.fire && ctrl.word.emit) begin
         data_ff <= byte_sel;
         last_ff <= ctrl.word.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.fire && ctrl.word.emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   assign status.out_free = !valid_ff || rsp_tready;
   assign status.no_params = (count_ff == '0);
   assign status.more_params = (idx_next < count_ff);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tlast = last_ff;

endmodule

// ----- hdl/servo_instruction_packet_framer.sv -----
// the first byte comes from the header step after the accepting wait step; a command
// takes one accept step, then 6 plus the clamped parameter count emit steps, one byte
// per cycle while the sink is ready, and no new command is taken before they end;
// the microprogram step counter paces the whole packet; a stalled sink holds the step
// reset: synchronous, active high; returns to the wait step with the output empty
module servo_instruction_packet_framer #(
   parameter int MAX_PARAMS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // servo_id[7:0], instruction[15:8], param_count[18:16], param_0[26:19],
   // param_1[34:27], param_2[42:35], param_3[50:43], zero pad[55:51]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tx_byte[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);
   import sif_pkg::*;

   localparam int PARAM_LIMIT = (MAX_PARAMS < PARAM_FIELDS) ? MAX_PARAMS : PARAM_FIELDS;

   ctrl_type   ctrl;
   status_type status;

   sif_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .ctrl       (ctrl)
   );

   sif_dp #(
      .PARAM_LIMIT (PARAM_LIMIT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_tdata  (req_tdata),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
